[hw/rtl/mctr_pkg.sv]
`timescale 1ns / 1ps

package mctr_pkg;

	// Field widths
	localparam int VAL_W     = 7;   // {state[3:0], strength[2:0]}
	localparam int STAMP_W   = 64;
	localparam int IDX_W     = 6;   // ring index, holds DEPTH-1 at the largest depth
	localparam int CNT_W     = 7;   // fill and match counts, hold DEPTH itself
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 4;

	// Opcodes
	localparam logic [1:0] OP_RECORD  = 2'd0;
	localparam logic [1:0] OP_QUERY   = 2'd1;
	localparam logic [1:0] OP_INITIAL = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_STATE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_STRENGTH = 2'd1;

	// Per-channel ring bookkeeping, one entry of the channel table
	typedef struct packed {
		logic [VAL_W-1:0] first_value;
		logic [CNT_W-1:0] fill;
		logic [IDX_W-1:0] next;
		logic [IDX_W-1:0] oldest;
	} mctr_meta_t;

	// Write request into the channel table
	typedef struct packed {
		logic       en;
		mctr_meta_t data;
	} mctr_meta_wr_t;

endpackage

[hw/rtl/multi_channel_trace_ring.sv]
`timescale 1ns / 1ps

// Per-channel circular trace buffer of time-stamped logic values (4-bit state,
// 3-bit strength, 64-bit stamp), CHANNELS rings of DEPTH entries each. Samples
// live in one single-port-read sample memory, ring pointers and fill counts in
// a per-channel table memory; both have registered reads. One word is handled
// at a time: a record has a table read, then write-back of table and sample; an
// initial-value read has a table read, then puts out its result; a window query
// reads the table, walks the entries (at most the channel's fill count), one
// entry per cycle through the sample memory read port unless a new match waits
// on a result side holding out_ready low, then puts out its last word. The
// finished result sits in an output register, so the next word is taken while
// it waits. There is no clearing pass after reset: per-channel written flags
// make every channel start empty at once.
module multi_channel_trace_ring
	import mctr_pkg::*;
#(
	parameter int CHANNELS = 16,
	parameter int DEPTH    = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	// input words
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [7:0]           channel,
	input  logic [3:0]           in_state,
	input  logic [2:0]           in_strength,
	input  logic [STAMP_W-1:0]   in_stamp,
	input  logic [STAMP_W-1:0]   window_start,
	input  logic [STAMP_W-1:0]   window_end,
	input  logic [CNT_W-1:0]     match_limit,
	// result words
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3:0]           out_state,
	output logic [2:0]           out_strength,
	output logic [STAMP_W-1:0]   out_stamp,
	output logic                 has_sample,
	output logic [CNT_W-1:0]     match_count,
	output logic                 last
);

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IW = $clog2(DEPTH);
	localparam int AW = CW + IW;
	localparam int DW = VAL_W + STAMP_W;
	localparam logic [IDX_W-1:0] WRAP_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_META, S_WALK, S_FLUSH} state_t;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == WRAP_IDX) ? '0 : i + 1'b1;
	endfunction

	state_t               state_q;
	logic [1:0]           op_q;
	logic [CW-1:0]        ch_q;
	logic                 chok_q;
	logic [VAL_W-1:0]     val_q;
	logic [STAMP_W-1:0]   stamp_q;
	logic [STAMP_W-1:0]   ws_q;
	logic [STAMP_W-1:0]   we_q;
	logic [CNT_W-1:0]     limit_q;
	logic [CNT_W-1:0]     fill_q;
	logic [IDX_W-1:0]     cur_q;
	logic [CNT_W-1:0]     step_q;
	logic [CNT_W-1:0]     n_q;
	logic                 pend_valid_q;
	logic [VAL_W-1:0]     pend_val_q;
	logic [STAMP_W-1:0]   pend_stamp_q;
	logic [CNT_W-1:0]     pend_cnt_q;
	logic                 out_valid_q;
	logic [VAL_W-1:0]     out_val_q;
	logic [STAMP_W-1:0]   out_stamp_q;
	logic                 out_has_q;
	logic [CNT_W-1:0]     out_cnt_q;
	logic                 out_last_q;
	logic [3:0]           unk_state_q;
	logic [2:0]           unk_str_q;

	logic                 in_acc;
	logic                 chok_in;
	mctr_meta_t           meta_rd;
	mctr_meta_wr_t        meta_wr;
	logic [DW-1:0]        smp_rd;
	logic [VAL_W-1:0]     smp_val;
	logic [STAMP_W-1:0]   smp_stamp;
	logic                 smp_wr_en;
	logic [IDX_W-1:0]     cur_d;
	logic                 out_free;
	logic                 out_load;
	logic                 hit;
	logic                 end_walk;
	logic                 stall;
	logic [VAL_W-1:0]     unk_val;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign chok_in   = ({1'b0, channel} < 9'(CHANNELS));
	assign unk_val   = {unk_state_q, unk_str_q};
	assign out_free  = !out_valid_q || out_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unk_state_q <= 4'd2;
			unk_str_q   <= 3'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_UNKNOWN_STATE:    unk_state_q <= cfg_data;
				REG_UNKNOWN_STRENGTH: unk_str_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Channel table: read at accept, written back in S_META. The FSM takes no
	// new word until the write-back is done, so a read never overlaps it.
	mctr_meta_mem #(
		.CHANNELS(CHANNELS),
		.CW      (CW)
	) u_meta (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_acc && chok_in),
		.rd_addr(channel[CW-1:0]),
		.rd_data(meta_rd),
		.wr     (meta_wr),
		.wr_addr(ch_q)
	);

	// Updated bookkeeping for a record
	always_comb begin
		meta_wr.en               = (state_q == S_META) && (op_q == OP_RECORD) && chok_q;
		meta_wr.data.first_value = (meta_rd.fill == '0) ? val_q : meta_rd.first_value;
		meta_wr.data.next        = idx_inc(meta_rd.next);
		if (meta_rd.fill < DEPTH_C) begin
			meta_wr.data.fill   = meta_rd.fill + 1'b1;
			meta_wr.data.oldest = meta_rd.oldest;
		end else begin
			meta_wr.data.fill   = meta_rd.fill;
			meta_wr.data.oldest = idx_inc(meta_rd.oldest);
		end
	end

	assign smp_wr_en = meta_wr.en;

	// Walk step on the sample currently in the read register
	assign smp_val   = smp_rd[DW-1:STAMP_W];
	assign smp_stamp = smp_rd[STAMP_W-1:0];
	assign hit       = (smp_stamp >= ws_q) && (smp_stamp < we_q);
	assign end_walk  = (step_q + 1'b1 == fill_q) || (hit && (n_q + 1'b1 == limit_q));
	assign stall     = hit && pend_valid_q && !out_free;

	// A word enters the result register: a held match pushed out by a newer
	// one, or the closing word of the input
	assign out_load  = ((state_q == S_WALK) && hit && pend_valid_q && out_free) ||
		((state_q == S_FLUSH) && out_free);

	// Next read pointer: oldest entry at walk start, then one entry per step
	always_comb begin
		cur_d = cur_q;
		case (state_q)
			S_META:  cur_d = meta_rd.oldest;
			S_WALK:  if (!stall && !end_walk) cur_d = idx_inc(cur_q);
			default: cur_d = cur_q;
		endcase
	end

	mctr_sample_mem #(
		.AW(AW),
		.DW(DW)
	) u_samples (
		.clk    (clk),
		.wr_en  (smp_wr_en),
		.wr_addr({ch_q, meta_rd.next[IW-1:0]}),
		.wr_data({val_q, stamp_q}),
		.rd_addr({ch_q, cur_d[IW-1:0]}),
		.rd_data(smp_rd)
	);

	// Control FSM and result register. A matched sample is held back one step
	// so that its last flag is known before it goes out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= '0;
			ch_q         <= '0;
			chok_q       <= 1'b0;
			val_q        <= '0;
			stamp_q      <= '0;
			ws_q         <= '0;
			we_q         <= '0;
			limit_q      <= '0;
			fill_q       <= '0;
			cur_q        <= '0;
			step_q       <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			pend_val_q   <= '0;
			pend_stamp_q <= '0;
			pend_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
			out_val_q    <= '0;
			out_stamp_q  <= '0;
			out_has_q    <= 1'b0;
			out_cnt_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			cur_q <= cur_d;
			// result valid: set on load, cleared once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q    <= opcode;
						ch_q    <= channel[CW-1:0];
						chok_q  <= chok_in;
						val_q   <= {in_state, in_strength};
						stamp_q <= in_stamp;
						ws_q    <= window_start;
						we_q    <= window_end;
						limit_q <= match_limit;
						state_q <= S_META;
					end
				end
				S_META: begin
					step_q <= '0;
					n_q    <= '0;
					fill_q <= meta_rd.fill;
					case (op_q)
						OP_QUERY: begin
							pend_valid_q <= 1'b0;
							if (chok_q && meta_rd.fill != '0 && limit_q != '0) begin
								state_q <= S_WALK;
							end else begin
								state_q <= S_FLUSH;
							end
						end
						OP_INITIAL: begin
							pend_valid_q <= 1'b1;
							pend_val_q   <= (chok_q && meta_rd.fill != '0) ?
								meta_rd.first_value : unk_val;
							pend_stamp_q <= '0;
							pend_cnt_q   <= '0;
							state_q      <= S_FLUSH;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_WALK: begin
					if (!stall) begin
						if (hit) begin
							if (pend_valid_q) begin
								out_val_q   <= pend_val_q;
								out_stamp_q <= pend_stamp_q;
								out_has_q   <= 1'b1;
								out_cnt_q   <= pend_cnt_q;
								out_last_q  <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_val_q   <= smp_val;
							pend_stamp_q <= smp_stamp;
							pend_cnt_q   <= n_q + 1'b1;
							n_q          <= n_q + 1'b1;
						end
						step_q <= step_q + 1'b1;
						if (end_walk) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						out_last_q  <= 1'b1;
						if (pend_valid_q) begin
							out_val_q   <= pend_val_q;
							out_stamp_q <= pend_stamp_q;
							out_has_q   <= 1'b1;
							out_cnt_q   <= pend_cnt_q;
						end else begin
							out_val_q   <= '0;
							out_stamp_q <= '0;
							out_has_q   <= 1'b0;
							out_cnt_q   <= '0;
						end
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_state    = out_val_q[VAL_W-1:3];
	assign out_strength = out_val_q[2:0];
	assign out_stamp    = out_stamp_q;
	assign has_sample   = out_has_q;
	assign match_count  = out_cnt_q;
	assign last         = out_last_q;

endmodule

[hw/rtl/mctr_meta_mem.sv]
`timescale 1ns / 1ps

module mctr_meta_mem
	import mctr_pkg::*;
#(
	parameter int CHANNELS = 16,
	parameter int CW       = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [CW-1:0] rd_addr,
	output mctr_meta_t    rd_data,
	input  mctr_meta_wr_t wr,
	input  logic [CW-1:0] wr_addr
);

	mctr_meta_t          mem [CHANNELS];
	logic [CHANNELS-1:0] written_q;
	mctr_meta_t          rd_q;
	logic                rd_written_q;

	// Table body, no reset; registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Entry-written flags; an unwritten channel reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_q : '0;

endmodule

[hw/rtl/mctr_sample_mem.sv]
`timescale 1ns / 1ps

module mctr_sample_mem #(
	parameter int AW = 10,
	parameter int DW = 71
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [2**AW];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[hw/rtl/mctr_checker.sv]
`timescale 1ns / 1ps

module mctr_checker
	import mctr_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [3:0]         out_state,
	input logic [2:0]         out_strength,
	input logic [STAMP_W-1:0] out_stamp,
	input logic               has_sample,
	input logic [CNT_W-1:0]   match_count,
	input logic               last
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_stamp) &&
			$stable(match_count) && $stable(last))
		else $error("result word changed while stalled");

	// Empty query result carries nothing and closes the query
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_sample |-> last && match_count == '0 && out_stamp == '0 &&
			out_state == '0 && out_strength == '0)
		else $error("malformed empty result");

	// Initial-value result is a single word with no stamp
	a_initial: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_sample && match_count == '0 |-> last && out_stamp == '0)
		else $error("malformed initial-value result");

	// Every word needs the channel table read first
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken during table lookup");

endmodule

bind multi_channel_trace_ring mctr_checker u_mctr_checker (.*);
